>>> rtl/core/dmrt_pkg.sv
// Shared types and constants for the D2Q9 MRT collision pipeline.
// Depends on nothing; imported by the collision top level.
`timescale 1ns / 1ps

package dmrt_pkg;

  localparam int FRAC_BITS = 28;
  localparam int NUM_DIST  = 9;
  localparam int NUM_STAGE = 13;

  // Fixed-point one in Q.28.
  localparam logic signed [39:0] ONE_Q = 40'sd268435456;

  // Reset value of the stress relaxation rate: 1.0 in Q2.28.
  localparam logic [29:0] RELAX_RESET = 30'd268435456;

  // Division by 180 via floor reciprocal: q = (x * RECIP) >> 36, then one fix-up step.
  localparam logic [28:0] RECIP_180   = 29'd381774870;
  localparam int          RECIP_SHIFT = 36;
  localparam logic [27:0] DIV_180     = 28'd180;
  localparam logic [41:0] HALF_180    = 42'd90;

  // Row magnitudes above this already saturate the result, so they are clamped to it.
  localparam logic [43:0] ROW_LIMIT = 44'h1FF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] dist_rest;
    logic signed [31:0] dist_0;
    logic signed [31:0] dist_1;
    logic signed [31:0] dist_2;
    logic signed [31:0] dist_3;
    logic signed [31:0] dist_4;
    logic signed [31:0] dist_5;
    logic signed [31:0] dist_6;
    logic signed [31:0] dist_7;
    logic signed [31:0] density;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_rest;
    logic signed [31:0] new_0;
    logic signed [31:0] new_1;
    logic signed [31:0] new_2;
    logic signed [31:0] new_3;
    logic signed [31:0] new_4;
    logic signed [31:0] new_5;
    logic signed [31:0] new_6;
    logic signed [31:0] new_7;
  } out_word_t;

endpackage

>>> rtl/core/d2q9_mrt_collision.sv
// D2Q9 multiple-relaxation-time collision, thirteen-stage pipeline.
// Depends on dmrt_pkg for the word types and fixed-point constants.
`timescale 1ns / 1ps

//  Channel  | Signals                              | Direction | Word
//  ---------+--------------------------------------+-----------+---------------------------
//  input    | in_valid_i, in_ready_o, in_data_i    | in        | nine dists, density, vel
//  output   | out_valid_o, out_ready_i, out_data_o | out       | nine relaxed dists
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i | in        | stress relaxation rate
//
// One word enters per cycle and its result passes through the 13 register stages (products,
// moments, rows, and a two-part division by 180) before it leaves.
// Throughput is one word per cycle as long as the output is taken.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the relaxation rate to 1.0.
// Each stage holds its word while the stage behind it is full and stalled, so a stall
// fills bubbles first and never drops or repeats a word.

module d2q9_mrt_collision (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dmrt_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dmrt_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [29:0]         cfg_data_i
);
  import dmrt_pkg::*;

  // Saturate a 40-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] res;
    if (x > 40'sh00_7FFF_FFFF)       res = 32'sh7FFF_FFFF;
    else if (x < -40'sh00_8000_0000) res = -32'sh8000_0000;
    else                             res = x[31:0];
    return res;
  endfunction

  // Clamp a 40-bit signed value to 34 bits.
  function automatic logic signed [33:0] clamp34(input logic signed [39:0] x);
    logic signed [33:0] res;
    if (x > 40'sh01_FFFF_FFFF)       res = 34'sh1_FFFF_FFFF;
    else if (x < -40'sh02_0000_0000) res = -34'sh2_0000_0000;
    else                             res = x[33:0];
    return res;
  endfunction

  // Quotient estimate of x / 180 for x below 180 * 2^20; low by at most one.
  function automatic logic [19:0] est180(input logic [27:0] x);
    logic [56:0] prod;
    prod = 57'(x) * 57'(RECIP_180);
    prod = prod >> RECIP_SHIFT;
    return prod[19:0];
  endfunction

  // Configuration register: the stress relaxation rate, taken at any time.
  logic [29:0] relax_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= RELAX_RESET;
    end else if (cfg_valid_i) begin
      relax_q <= cfg_data_i;
    end
  end

  // Pipeline flow control: a stage loads when it is empty or the one behind it moves.
  logic [NUM_STAGE-1:0] v_q;
  logic [NUM_STAGE:0]   en;

  always_comb begin
    en[NUM_STAGE] = out_ready_i;
    for (int s = NUM_STAGE - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NUM_STAGE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NUM_STAGE; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // The input distributions travel alongside the word through stages 0 to 11,
  // because the last stage subtracts the relaxed correction from them.
  logic signed [31:0] din [NUM_DIST];
  logic signed [31:0] dp_q [NUM_STAGE-1][NUM_DIST];

  assign din[0] = in_data_i.dist_rest;
  assign din[1] = in_data_i.dist_0;
  assign din[2] = in_data_i.dist_1;
  assign din[3] = in_data_i.dist_2;
  assign din[4] = in_data_i.dist_3;
  assign din[5] = in_data_i.dist_4;
  assign din[6] = in_data_i.dist_5;
  assign din[7] = in_data_i.dist_6;
  assign din[8] = in_data_i.dist_7;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dp_q[0] <= din;
    end
    for (int s = 1; s < NUM_STAGE - 1; s++) begin
      if (en[s]) begin
        dp_q[s] <= dp_q[s-1];
      end
    end
  end

  // Stage 0: velocity products and momentum, each a Q.28 product with floor rounding.
  logic signed [63:0] pr_uu, pr_vv, pr_uv, pr_ru, pr_rv;
  logic signed [31:0] rho0_q;
  logic signed [35:0] uu0_q, vv0_q, uv0_q, ru0_q, rv0_q;

  assign pr_uu = in_data_i.vel_x * in_data_i.vel_x;
  assign pr_vv = in_data_i.vel_y * in_data_i.vel_y;
  assign pr_uv = in_data_i.vel_x * in_data_i.vel_y;
  assign pr_ru = in_data_i.density * in_data_i.vel_x;
  assign pr_rv = in_data_i.density * in_data_i.vel_y;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rho0_q <= in_data_i.density;
      uu0_q  <= pr_uu[63:28];
      vv0_q  <= pr_vv[63:28];
      uv0_q  <= pr_uv[63:28];
      ru0_q  <= pr_ru[63:28];
      rv0_q  <= pr_rv[63:28];
    end
  end

  // Stage 1: the four equilibrium factors, each clamped to 32 bits.
  logic signed [39:0] mag1;
  logic signed [31:0] rho1_q;
  logic signed [35:0] ru1_q, rv1_q;
  logic signed [31:0] f1_q [4];

  assign mag1 = 40'(uu0_q) + 40'(vv0_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rho1_q  <= rho0_q;
      ru1_q   <= ru0_q;
      rv1_q   <= rv0_q;
      f1_q[0] <= sat32(40'(3 * mag1) - (ONE_Q <<< 1));
      f1_q[1] <= sat32(ONE_Q - 40'(3 * mag1));
      f1_q[2] <= sat32(40'(uu0_q) - 40'(vv0_q));
      f1_q[3] <= sat32(40'(uv0_q));
    end
  end

  // Stage 2: density times each factor.
  logic signed [63:0] pr_f [4];
  logic signed [31:0] rho2_q;
  logic signed [35:0] ru2_q, rv2_q;
  logic signed [35:0] p2_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pr_f[k] = rho1_q * f1_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rho2_q <= rho1_q;
      ru2_q  <= ru1_q;
      rv2_q  <= rv1_q;
      for (int k = 0; k < 4; k++) begin
        p2_q[k] <= pr_f[k][63:28];
      end
    end
  end

  // Stage 3: group sums of the distributions that the moments share.
  logic signed [39:0] dx [NUM_DIST];
  logic signed [31:0] rho3_q;
  logic signed [35:0] ru3_q, rv3_q;
  logic signed [35:0] p3_q [4];
  logic signed [39:0] sa3_q, sb3_q;
  logic signed [39:0] t3_q [6];

  always_comb begin
    for (int k = 0; k < NUM_DIST; k++) begin
      dx[k] = 40'(dp_q[2][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      rho3_q  <= rho2_q;
      ru3_q   <= ru2_q;
      rv3_q   <= rv2_q;
      p3_q    <= p2_q;
      sa3_q   <= dx[1] + dx[3] + dx[5] + dx[7];
      sb3_q   <= dx[2] + dx[4] + dx[6] + dx[8];
      t3_q[0] <= dx[1] - dx[5] + dx[2] - dx[4] - dx[6] + dx[8];
      t3_q[1] <= 2 * (dx[5] - dx[1]) + dx[2] - dx[4] - dx[6] + dx[8];
      t3_q[2] <= dx[2] + dx[3] + dx[4] - dx[6] - dx[7] - dx[8];
      t3_q[3] <= dx[2] - 2 * dx[3] + dx[4] - dx[6] + 2 * dx[7] - dx[8];
      t3_q[4] <= dx[1] - dx[3] + dx[5] - dx[7];
      t3_q[5] <= dx[2] - dx[4] + dx[6] - dx[8];
    end
  end

  // Stage 4: moment deviations from equilibrium, clamped to 34 bits.
  logic signed [39:0] d04, rh4, ru4, rv4;
  logic signed [39:0] pe4 [4];
  logic signed [33:0] m4_q [NUM_DIST];

  assign d04 = 40'(dp_q[3][0]);
  assign rh4 = 40'(rho3_q);
  assign ru4 = 40'(ru3_q);
  assign rv4 = 40'(rv3_q);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pe4[k] = 40'(p3_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      m4_q[0] <= clamp34(d04 + sa3_q + sb3_q - rh4);
      m4_q[1] <= clamp34(-4 * d04 - sa3_q + 2 * sb3_q - pe4[0]);
      m4_q[2] <= clamp34(4 * d04 - 2 * sa3_q + sb3_q - pe4[1]);
      m4_q[3] <= clamp34(t3_q[0] - ru4);
      m4_q[4] <= clamp34(t3_q[1] + ru4);
      m4_q[5] <= clamp34(t3_q[2] - rv4);
      m4_q[6] <= clamp34(t3_q[3] + rv4);
      m4_q[7] <= clamp34(t3_q[4] - pe4[2]);
      m4_q[8] <= clamp34(t3_q[5] - pe4[3]);
    end
  end

  // Stage 5: omega on the two stress moments, and the shared partial rows.
  logic signed [30:0] om5;
  logic signed [64:0] pr_om7, pr_om8;
  logic signed [43:0] mw [NUM_DIST];
  logic signed [36:0] qm5_q [2];
  logic signed [43:0] c5_q [3];
  logic signed [43:0] g5_q [4];

  assign om5    = {1'b0, relax_q};
  assign pr_om7 = om5 * m4_q[7];
  assign pr_om8 = om5 * m4_q[8];

  always_comb begin
    for (int k = 0; k < NUM_DIST; k++) begin
      mw[k] = 44'(m4_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      qm5_q[0] <= pr_om7[64:28];
      qm5_q[1] <= pr_om8[64:28];
      c5_q[0]  <= 20 * mw[0] - 24 * mw[1] + 20 * mw[2];
      c5_q[1]  <= 20 * mw[0] - 6 * mw[1] - 10 * mw[2];
      c5_q[2]  <= 20 * mw[0] + 12 * mw[1] + 5 * mw[2];
      g5_q[0]  <= 30 * mw[3] - 36 * mw[4];
      g5_q[1]  <= 30 * mw[5] - 36 * mw[6];
      g5_q[2]  <= 30 * mw[3] + 18 * mw[4];
      g5_q[3]  <= 30 * mw[5] + 18 * mw[6];
    end
  end

  // Stage 6: the nine back-mapping rows over the common denominator 180.
  logic signed [43:0] w7, w8;
  logic signed [43:0] r6_q [NUM_DIST];

  assign w7 = 45 * 44'(qm5_q[0]);
  assign w8 = 45 * 44'(qm5_q[1]);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      r6_q[0] <= c5_q[0];
      r6_q[1] <= c5_q[1] + g5_q[0] + w7;
      r6_q[3] <= c5_q[1] + g5_q[1] - w7;
      r6_q[5] <= c5_q[1] - g5_q[0] + w7;
      r6_q[7] <= c5_q[1] - g5_q[1] - w7;
      r6_q[2] <= c5_q[2] + g5_q[2] + g5_q[3] + w8;
      r6_q[4] <= c5_q[2] - g5_q[2] + g5_q[3] - w8;
      r6_q[6] <= c5_q[2] - g5_q[2] - g5_q[3] + w8;
      r6_q[8] <= c5_q[2] + g5_q[2] - g5_q[3] - w8;
    end
  end

  // Stage 7: sign and magnitude, plus half the divisor for round-half-away.
  // Magnitudes that saturate the result anyway are clamped to keep the divider narrow.
  logic [43:0] mg7 [NUM_DIST];
  logic        ng7_q [NUM_DIST];
  logic [41:0] t7_q [NUM_DIST];

  always_comb begin
    for (int k = 0; k < NUM_DIST; k++) begin
      mg7[k] = r6_q[k][43] ? 44'(-r6_q[k]) : 44'(r6_q[k]);
      if (mg7[k] > ROW_LIMIT) begin
        mg7[k] = ROW_LIMIT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      for (int k = 0; k < NUM_DIST; k++) begin
        ng7_q[k] <= r6_q[k][43];
        t7_q[k]  <= mg7[k][41:0] + HALF_180;
      end
    end
  end

  // Stage 8: estimate of the upper quotient digit (upper 22 bits over 180).
  logic        ng8_q [NUM_DIST];
  logic [14:0] qh8_q [NUM_DIST];
  logic [21:0] th8_q [NUM_DIST];
  logic [19:0] tl8_q [NUM_DIST];
  logic [19:0] eh8 [NUM_DIST];

  always_comb begin
    for (int k = 0; k < NUM_DIST; k++) begin
      eh8[k] = est180(28'(t7_q[k][41:20]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      for (int k = 0; k < NUM_DIST; k++) begin
        ng8_q[k] <= ng7_q[k];
        qh8_q[k] <= eh8[k][14:0];
        th8_q[k] <= t7_q[k][41:20];
        tl8_q[k] <= t7_q[k][19:0];
      end
    end
  end

  // Stage 9: fix up the upper digit and join its remainder to the lower bits.
  logic [21:0] rm9 [NUM_DIST];
  logic        fx9 [NUM_DIST];
  logic        ng9_q [NUM_DIST];
  logic [14:0] qh9_q [NUM_DIST];
  logic [27:0] x9_q [NUM_DIST];

  always_comb begin
    for (int k = 0; k < NUM_DIST; k++) begin
      rm9[k] = th8_q[k] - 22'(qh8_q[k]) * DIV_180[21:0];
      fx9[k] = rm9[k] >= DIV_180[21:0];
      if (fx9[k]) begin
        rm9[k] = rm9[k] - DIV_180[21:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      for (int k = 0; k < NUM_DIST; k++) begin
        ng9_q[k] <= ng8_q[k];
        qh9_q[k] <= qh8_q[k] + 15'(fx9[k]);
        x9_q[k]  <= {rm9[k][7:0], tl8_q[k]};
      end
    end
  end

  // Stage 10: estimate of the lower quotient digit.
  logic        ng10_q [NUM_DIST];
  logic [14:0] qh10_q [NUM_DIST];
  logic [27:0] x10_q [NUM_DIST];
  logic [19:0] ql10_q [NUM_DIST];

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      for (int k = 0; k < NUM_DIST; k++) begin
        ng10_q[k] <= ng9_q[k];
        qh10_q[k] <= qh9_q[k];
        x10_q[k]  <= x9_q[k];
        ql10_q[k] <= est180(x9_q[k]);
      end
    end
  end

  // Stage 11: fix up the lower digit and restore the sign of the quotient.
  logic [27:0] rm11 [NUM_DIST];
  logic [34:0] qm11 [NUM_DIST];
  logic signed [35:0] q11_q [NUM_DIST];

  always_comb begin
    for (int k = 0; k < NUM_DIST; k++) begin
      rm11[k] = x10_q[k] - 28'(ql10_q[k]) * DIV_180;
      qm11[k] = {qh10_q[k], ql10_q[k]} + 35'(rm11[k] >= DIV_180);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      for (int k = 0; k < NUM_DIST; k++) begin
        q11_q[k] <= ng10_q[k] ? -$signed({1'b0, qm11[k]}) : $signed({1'b0, qm11[k]});
      end
    end
  end

  // Stage 12: subtract the correction from each distribution and saturate.
  logic signed [31:0] nw [NUM_DIST];
  out_word_t          out_q;

  always_comb begin
    for (int k = 0; k < NUM_DIST; k++) begin
      nw[k] = sat32(40'(dp_q[11][k]) - 40'(q11_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      out_q.new_rest <= nw[0];
      out_q.new_0    <= nw[1];
      out_q.new_1    <= nw[2];
      out_q.new_2    <= nw[3];
      out_q.new_3    <= nw[4];
      out_q.new_4    <= nw[5];
      out_q.new_5    <= nw[6];
      out_q.new_6    <= nw[7];
      out_q.new_7    <= nw[8];
    end
  end

  assign out_data_o = out_q;

endmodule
